>>> hdl/prht_pkg.sv
// package: types, stage codes and word layouts for the raw hazard tracker
package prht_pkg;

   localparam int NUM_STAGES     = 8;
   localparam int STAGE_BITS     = $clog2(NUM_STAGES);
   localparam int SHIFT_BITS     = $clog2(NUM_STAGES + 1);
   localparam int DEF_REG_BITS   = 5;
   localparam int DEF_COUNT_BITS = 32;
   localparam int ST_ID          = 2;
   localparam int ST_EXE1        = 3;
   localparam int ST_MEM2        = 6;
   localparam int NUM_HAZ_STAGES = ST_MEM2 - ST_EXE1 + 1;
   localparam int REPORT_BITS    = 32;
   localparam int INC_BITS       = 8;

   typedef enum logic [2:0] {
      KIND_TICK  = 3'd0,
      KIND_READ  = 3'd1,
      KIND_WRITE = 3'd2,
      KIND_FLUSH = 3'd3,
      KIND_STALL = 3'd4
   } kind_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [4:0] reg_num;
      logic [2:0] stage_code;
      logic [7:0] amount;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  bubbles_added;
      logic        hazard_found;
      logic [2:0]  hazard_position;
      logic [31:0] cycle_total;
      logic [31:0] bubble_total;
      logic [31:0] flush_total;
      logic [31:0] stall_total;
      logic [31:0] hazard_total;
      logic [31:0] exe1_hazards;
      logic [31:0] exe2_hazards;
      logic [31:0] mem1_hazards;
      logic [31:0] mem2_hazards;
   } rsp_word_type;

   typedef struct packed {
      logic       found;
      logic [2:0] bubbles;
      logic [2:0] position;
   } scan_result_type;

endpackage

>>> hdl/prht_sat_counter.sv
// saturating event counter with a 32-bit clipped report
module prht_sat_counter
   import prht_pkg::*;
#(
   parameter int COUNT_BITS = DEF_COUNT_BITS,
   parameter int INIT_VALUE = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic [INC_BITS-1:0]    increment,
   output logic [REPORT_BITS-1:0] report
);

   logic [COUNT_BITS-1:0]             count_ff;
   logic [COUNT_BITS-1:0]             count_in;
   logic [COUNT_BITS:0]               sum;
   logic [COUNT_BITS+REPORT_BITS-1:0] ext;

   assign sum = {1'b0, count_ff} + (COUNT_BITS + 1)'(increment);

   always_comb begin
      count_in = count_ff;
      if (enable) begin
         if (sum[COUNT_BITS]) begin
            count_in = '1;
         end else begin
            count_in = sum[COUNT_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_BITS'(INIT_VALUE);
      end else begin
         count_ff <= count_in;
      end
   end

   assign ext = {{REPORT_BITS{1'b0}}, count_ff};

   always_comb begin
      if (|ext[COUNT_BITS+REPORT_BITS-1:REPORT_BITS]) begin
         report = '1;
      end else begin
         report = ext[REPORT_BITS-1:0];
      end
   end

endmodule

>>> hdl/prht_scoreboard.sv
// stage scoreboard: producer scan, bubble count and pipe shifts
module prht_scoreboard
   import prht_pkg::*;
#(
   parameter int REG_BITS = DEF_REG_BITS
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  req_word_type    req,
   output scan_result_type scan
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [REG_BITS-1:0]   dest_ff [NUM_STAGES];
   logic [REG_BITS-1:0]   dest_in [NUM_STAGES];
   logic [2:0]            rdy_ff  [NUM_STAGES];
   logic [2:0]            rdy_in  [NUM_STAGES];
   logic [REG_BITS-1:0]   rd_reg;
   logic [2:0]            need;
   logic [SHIFT_BITS-1:0] shift;
   logic signed [4:0]     diff;

   assign rd_reg = REG_BITS'(req.reg_num);
   assign need   = (req.stage_code < 3'(ST_ID)) ? 3'(ST_ID) : req.stage_code;

   // nearest producer wins, so scan from the far end towards exe1
   always_comb begin
      scan = '0;
      diff = '0;
      if (req.kind == KIND_READ && rd_reg != '0) begin
         for (int i = ST_MEM2; i >= ST_EXE1; i--) begin
            if (valid_ff[i] && dest_ff[i] == rd_reg) begin
               diff = $signed({2'b00, rdy_ff[i]}) - $signed(5'(i))
                    - $signed({2'b00, need}) + $signed(5'(ST_ID));
               scan.found    = 1'b1;
               scan.position = 3'(i - ST_ID);
               scan.bubbles  = (diff > 5'sd0) ? diff[2:0] : 3'd0;
            end
         end
      end
   end

   always_comb begin
      if (req.kind == KIND_TICK) begin
         shift = SHIFT_BITS'(1);
      end else if (req.amount >= 8'(NUM_STAGES)) begin
         shift = SHIFT_BITS'(NUM_STAGES);
      end else begin
         shift = req.amount[SHIFT_BITS-1:0];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      dest_in  = dest_ff;
      rdy_in   = rdy_ff;
      case (req.kind)
         KIND_TICK, KIND_FLUSH: begin
            for (int j = 0; j < NUM_STAGES; j++) begin
               if (j >= int'(shift)) begin
                  valid_in[j] = valid_ff[STAGE_BITS'(j - int'(shift))];
                  dest_in[j]  = dest_ff[STAGE_BITS'(j - int'(shift))];
                  rdy_in[j]   = rdy_ff[STAGE_BITS'(j - int'(shift))];
               end else begin
                  valid_in[j] = 1'b0;
                  dest_in[j]  = '0;
                  rdy_in[j]   = '0;
               end
            end
         end
         KIND_READ: begin
            for (int j = ST_EXE1; j < NUM_STAGES; j++) begin
               if (j - int'(scan.bubbles) >= ST_EXE1) begin
                  valid_in[j] = valid_ff[STAGE_BITS'(j - int'(scan.bubbles))];
                  dest_in[j]  = dest_ff[STAGE_BITS'(j - int'(scan.bubbles))];
                  rdy_in[j]   = rdy_ff[STAGE_BITS'(j - int'(scan.bubbles))];
               end else begin
                  valid_in[j] = 1'b0;
                  dest_in[j]  = '0;
                  rdy_in[j]   = '0;
               end
            end
         end
         KIND_WRITE: begin
            valid_in[ST_ID] = 1'b1;
            dest_in[ST_ID]  = rd_reg;
            rdy_in[ST_ID]   = req.stage_code;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (accept) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dest_ff <= dest_in;
         rdy_ff  <= rdy_in;
      end
   end

endmodule

>>> hdl/pipeline_raw_hazard_tracker_top.sv
// top level: raw hazard tracker with scoreboard, counters and result register
//
//   channel  direction  payload        handshake
//   req      in         req_word_type  req_valid / req_ready
//   rsp      out        rsp_word_type  rsp_valid / rsp_ready
//
// one word per cycle: each word is scanned and applied in the cycle it is
// accepted, its result word appears on rsp in the next cycle
// throughput set by the single result register: req_ready is high while
// that register is empty or being emptied
// reset (synchronous) empties the scoreboard, clears the counters and
// sets the cycle count to the stage count minus one
module pipeline_raw_hazard_tracker_top
   import prht_pkg::*;
#(
   parameter int REG_BITS   = DEF_REG_BITS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   logic                      accept;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   scan_result_type           scan;
   scan_result_type           scan_ff;
   logic [INC_BITS-1:0]       cycle_inc;
   logic [INC_BITS-1:0]       bubble_inc;
   logic [INC_BITS-1:0]       flush_inc;
   logic [INC_BITS-1:0]       stall_inc;
   logic [INC_BITS-1:0]       hazard_inc;
   logic [REPORT_BITS-1:0]    cycle_report;
   logic [REPORT_BITS-1:0]    bubble_report;
   logic [REPORT_BITS-1:0]    flush_report;
   logic [REPORT_BITS-1:0]    stall_report;
   logic [REPORT_BITS-1:0]    hazard_report;
   logic [REPORT_BITS-1:0]    stage_report [NUM_HAZ_STAGES];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   prht_scoreboard #(
      .REG_BITS (REG_BITS)
   ) u_scoreboard (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_word),
      .scan   (scan)
   );

   always_comb begin
      cycle_inc = '0;
      flush_inc = '0;
      stall_inc = '0;
      case (req_word.kind)
         KIND_TICK:  cycle_inc = INC_BITS'(1);
         KIND_READ:  cycle_inc = INC_BITS'(scan.bubbles);
         KIND_FLUSH: begin
            cycle_inc = req_word.amount;
            flush_inc = req_word.amount;
         end
         KIND_STALL: begin
            cycle_inc = req_word.amount;
            stall_inc = req_word.amount;
         end
         default: begin
         end
      endcase
   end

   assign bubble_inc = INC_BITS'(scan.bubbles);
   assign hazard_inc = INC_BITS'(scan.found);

   prht_sat_counter #(.COUNT_BITS(COUNT_BITS), .INIT_VALUE(NUM_STAGES - 1)) u_cycle_cnt (
      .clock (clock), .reset (reset), .enable (accept),
      .increment (cycle_inc), .report (cycle_report)
   );

   prht_sat_counter #(.COUNT_BITS(COUNT_BITS)) u_bubble_cnt (
      .clock (clock), .reset (reset), .enable (accept),
      .increment (bubble_inc), .report (bubble_report)
   );

   prht_sat_counter #(.COUNT_BITS(COUNT_BITS)) u_flush_cnt (
      .clock (clock), .reset (reset), .enable (accept),
      .increment (flush_inc), .report (flush_report)
   );

   prht_sat_counter #(.COUNT_BITS(COUNT_BITS)) u_stall_cnt (
      .clock (clock), .reset (reset), .enable (accept),
      .increment (stall_inc), .report (stall_report)
   );

   prht_sat_counter #(.COUNT_BITS(COUNT_BITS)) u_hazard_cnt (
      .clock (clock), .reset (reset), .enable (accept),
      .increment (hazard_inc), .report (hazard_report)
   );

   for (genvar k = 0; k < NUM_HAZ_STAGES; k++) begin : g_stage_cnt
      logic [INC_BITS-1:0] stage_inc;
      assign stage_inc = INC_BITS'(scan.found && scan.position == 3'(k + 1));
      prht_sat_counter #(.COUNT_BITS(COUNT_BITS)) u_stage_cnt (
         .clock (clock), .reset (reset), .enable (accept),
         .increment (stage_inc), .report (stage_report[k])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         scan_ff <= scan;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_word.bubbles_added   = scan_ff.bubbles;
      rsp_word.hazard_found    = scan_ff.found;
      rsp_word.hazard_position = scan_ff.position;
      rsp_word.cycle_total     = cycle_report;
      rsp_word.bubble_total    = bubble_report;
      rsp_word.flush_total     = flush_report;
      rsp_word.stall_total     = stall_report;
      rsp_word.hazard_total    = hazard_report;
      rsp_word.exe1_hazards    = stage_report[0];
      rsp_word.exe2_hazards    = stage_report[1];
      rsp_word.mem1_hazards    = stage_report[2];
      rsp_word.mem2_hazards    = stage_report[3];
   end

endmodule

>>> hdl/prht_checker.sv
// port checker for the raw hazard tracker, bound to the top level
module prht_port_checker
   import prht_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_word
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // every accepted request word gives a result word in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no result after accepted request");

   // no hazard means no bubbles and no position
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.hazard_found |->
         rsp_word.bubbles_added == 3'd0 && rsp_word.hazard_position == 3'd0)
      else $error("bubbles or position without hazard");

   // a hazard names a producer stage from exe1 to mem2
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.hazard_found |->
         rsp_word.hazard_position >= 3'd1 && rsp_word.hazard_position <= 3'd4
         && rsp_word.bubbles_added <= 3'd4)
      else $error("hazard position or bubble count out of range");

   // counts are never reduced from one result to the next
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready ##1 rsp_valid |->
         rsp_word.cycle_total >= $past(rsp_word.cycle_total)
         && rsp_word.hazard_total >= $past(rsp_word.hazard_total))
      else $error("counter went backwards");

endmodule

bind pipeline_raw_hazard_tracker_top prht_port_checker u_prht_port_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
